// ===== rtl/csle_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// csle_pkg
// Shared constants, codes and types of the compressed-row element lookup.
// ----------------------------------------------------------------------------
package csle_pkg;

    // Default capacities, handed to the top level parameters.
    localparam int DEF_MAX_ROWS    = 1024;
    localparam int DEF_MAX_ENTRIES = 4096;
    localparam int DEF_COL_BITS    = 16;

    // Fixed port widths.
    localparam int CMD_W      = 2;
    localparam int SLOT_W     = 12;
    localparam int PTR_IN_W   = 13;
    localparam int ECOL_W     = 16;
    localparam int VAL_W      = 64;
    localparam int QROW_W     = 10;
    localparam int QCOL_W     = 16;
    localparam int STAT_W     = 2;
    localparam int ROWCNT_W   = 11;
    localparam int COLCNT_W   = 17;
    localparam int CFG_DATA_W = 17;
    localparam int CFG_IDX_W  = 1;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_LOAD_PTR   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD_ENTRY = 2'd1;
    localparam logic [CMD_W-1:0] CMD_LOOKUP     = 2'd2;

    // Status codes.
    localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STAT_W-1:0] STAT_BAD_DIM = 2'd1;
    localparam logic [STAT_W-1:0] STAT_OOB     = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_COL_COUNT = 1'b1;

    // Lookup sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PTR0,
        ST_PTR1,
        ST_SCAN
    } state_t;

    // Geometry and bounds check of a lookup, from the top level to the sequencer.
    typedef struct packed {
        logic bad_dim;
        logic out_of_bounds;
    } lookup_check_t;

endpackage : csle_pkg
`default_nettype wire

// ===== rtl/csr_sparse_element_lookup_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// csr_sparse_element_lookup_core
// Compressed-row sparse matrix store with single element lookup.
// ----------------------------------------------------------------------------
// A beat is taken when start is high and busy is low. Load beats (row pointer
// or entry) leave busy low and give no result. A lookup that fails the
// geometry or bounds check gives its result in the cycle after the beat and
// leaves the block ready. Any other lookup keeps busy high while the row
// pointer memory is read twice through its single read port and the entry
// memory is then read one entry per cycle; the next beat can be taken in
// the cycle the result shows. Results are strobed on result_valid for
// exactly one cycle and cannot be held off. The memories have no reset;
// a lookup must only touch row pointers and entries that were loaded.
// There is no clearing pass after reset.
// ----------------------------------------------------------------------------
module csr_sparse_element_lookup_core #(
    parameter int MAX_ROWS    = csle_pkg::DEF_MAX_ROWS,
    parameter int MAX_ENTRIES = csle_pkg::DEF_MAX_ENTRIES,
    parameter int COL_BITS    = csle_pkg::DEF_COL_BITS
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_wr_en,
    input  wire logic [csle_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [csle_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  wire logic                               start,
    output      logic                               busy,
    input  wire logic [csle_pkg::CMD_W-1:0]         command,
    input  wire logic [csle_pkg::SLOT_W-1:0]        slot,
    input  wire logic [csle_pkg::PTR_IN_W-1:0]      row_pointer,
    input  wire logic [csle_pkg::ECOL_W-1:0]        entry_column,
    input  wire logic [csle_pkg::VAL_W-1:0]         entry_value,
    input  wire logic [csle_pkg::QROW_W-1:0]        query_row,
    input  wire logic [csle_pkg::QCOL_W-1:0]        query_col,
    output      logic                               result_valid,
    output      logic [csle_pkg::VAL_W-1:0]         element_value,
    output      logic [csle_pkg::STAT_W-1:0]        status
);

    import csle_pkg::*;

    localparam logic [31:0] MAX_ROWS_W = 32'(MAX_ROWS);

    logic [ROWCNT_W-1:0] row_count_reg;
    logic [COLCNT_W-1:0] col_count_reg;
    logic [31:0]         rows_in_use;
    lookup_check_t       check;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg <= '0;
            col_count_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_ROW_COUNT: row_count_reg <= cfg_wdata[ROWCNT_W-1:0];
                CFG_COL_COUNT: col_count_reg <= cfg_wdata[COLCNT_W-1:0];
                default:       row_count_reg <= row_count_reg;
            endcase
        end
    end

    // Geometry and bounds check; the row count is capped at the store size.
    assign rows_in_use = (32'(row_count_reg) > MAX_ROWS_W) ? MAX_ROWS_W : 32'(row_count_reg);

    assign check.bad_dim       = (row_count_reg == '0) || (col_count_reg == '0);
    assign check.out_of_bounds = (32'(query_row) >= rows_in_use) ||
                                 (COLCNT_W'(query_col) >= col_count_reg);

    // Load and lookup sequencer with its memories.
    csle_seq #(
        .MAX_ROWS    (MAX_ROWS),
        .MAX_ENTRIES (MAX_ENTRIES),
        .COL_BITS    (COL_BITS)
    ) u_seq (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .command       (command),
        .slot          (slot),
        .row_pointer   (row_pointer),
        .entry_column  (entry_column),
        .entry_value   (entry_value),
        .query_row     (query_row),
        .query_col     (query_col),
        .check         (check),
        .result_valid  (result_valid),
        .element_value (element_value),
        .status        (status)
    );

    // A load beat never produces a result.
    a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (command != CMD_LOOKUP)) |=> !result_valid)
        else $error("result strobed after a load beat");

    // Error results always carry a zero value.
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (status != STAT_OK)) |-> (element_value == '0))
        else $error("error result with nonzero value");

    // A lookup under invalid geometry answers in the next cycle.
    a_bad_dim: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (command == CMD_LOOKUP) &&
         ((row_count_reg == '0) || (col_count_reg == '0)))
        |=> (result_valid && (status == STAT_BAD_DIM)))
        else $error("invalid geometry lookup not answered");

    // The sequencer only leaves idle on a lookup beat.
    a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start && (command == CMD_LOOKUP)))
        else $error("busy without a lookup beat");

endmodule : csr_sparse_element_lookup_core
`default_nettype wire

// ===== rtl/csle_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// csle_ram
// Simple dual-port synchronous RAM, one write and one read port, with the
// read data registered.
// ----------------------------------------------------------------------------
module csle_ram #(
    parameter int DEPTH  = 4096,
    parameter int ADDR_W = 12,
    parameter int DATA_W = 80
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [DATA_W-1:0] wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output      logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule : csle_ram
`default_nettype wire

// ===== rtl/csle_seq.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// csle_seq
// Load and lookup sequencer: writes the row pointer and entry memories on
// load beats, and walks a row's entries one memory read per cycle on lookups.
// ----------------------------------------------------------------------------
module csle_seq #(
    parameter int MAX_ROWS    = csle_pkg::DEF_MAX_ROWS,
    parameter int MAX_ENTRIES = csle_pkg::DEF_MAX_ENTRIES,
    parameter int COL_BITS    = csle_pkg::DEF_COL_BITS
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 start,
    output      logic                                 busy,
    input  wire logic [csle_pkg::CMD_W-1:0]           command,
    input  wire logic [csle_pkg::SLOT_W-1:0]          slot,
    input  wire logic [csle_pkg::PTR_IN_W-1:0]        row_pointer,
    input  wire logic [csle_pkg::ECOL_W-1:0]          entry_column,
    input  wire logic [csle_pkg::VAL_W-1:0]           entry_value,
    input  wire logic [csle_pkg::QROW_W-1:0]          query_row,
    input  wire logic [csle_pkg::QCOL_W-1:0]          query_col,
    input  wire csle_pkg::lookup_check_t              check,
    output      logic                                 result_valid,
    output      logic [csle_pkg::VAL_W-1:0]           element_value,
    output      logic [csle_pkg::STAT_W-1:0]          status
);

    import csle_pkg::*;

    localparam int RIDX_W  = $clog2(MAX_ROWS + 1);
    localparam int EIDX_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int PTR_W   = $clog2(MAX_ENTRIES + 1);
    localparam int ENT_W   = COL_BITS + VAL_W;
    localparam logic [31:0] MAX_ROWS_W    = 32'(MAX_ROWS);
    localparam logic [31:0] MAX_ENTRIES_W = 32'(MAX_ENTRIES);

    state_t state_reg, state_next;

    logic [RIDX_W-1:0] qrow_reg, qrow_next;
    logic [QCOL_W-1:0] qcol_reg, qcol_next;
    logic [PTR_W-1:0]  first_reg, first_next;
    logic [PTR_W-1:0]  last_reg, last_next;
    logic [PTR_W-1:0]  idx_reg, idx_next;

    logic              result_valid_reg, result_valid_next;
    logic [VAL_W-1:0]  element_value_reg, element_value_next;
    logic [STAT_W-1:0] status_reg, status_next;

    logic              accept;
    logic [31:0]       slot_w;
    logic [31:0]       ptr_w;
    logic [31:0]       ptr_clamped;

    logic              ptr_wr_en;
    logic [RIDX_W-1:0] ptr_wr_addr;
    logic [PTR_W-1:0]  ptr_wr_data;
    logic              ptr_rd_en;
    logic [RIDX_W-1:0] ptr_rd_addr;
    logic [PTR_W-1:0]  ptr_rd_data;

    logic              ent_wr_en;
    logic [EIDX_W-1:0] ent_wr_addr;
    logic [ENT_W-1:0]  ent_wr_data;
    logic              ent_rd_en;
    logic [EIDX_W-1:0] ent_rd_addr;
    logic [ENT_W-1:0]  ent_rd_data;

    logic [31:0]       scan_col;
    logic [31:0]       scan_qcol;
    logic [31:0]       idx_inc;

    // Stored columns keep only the configured column width.
    function automatic logic [COL_BITS-1:0] entry_column_masked(
        input logic [ECOL_W-1:0] col
    );
        logic [31:0] col_w;
        col_w = 32'(col);
        return col_w[COL_BITS-1:0];
    endfunction

    // Items are taken only while the sequencer is idle, so loads and lookups
    // never overlap on the same memory entry.
    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;

    // Load beats: range check of the slot and clamp of the row pointer.
    assign slot_w      = 32'(slot);
    assign ptr_w       = 32'(row_pointer);
    assign ptr_clamped = (ptr_w > MAX_ENTRIES_W) ? MAX_ENTRIES_W : ptr_w;

    assign ptr_wr_en   = accept && (command == CMD_LOAD_PTR) && (slot_w <= MAX_ROWS_W);
    assign ptr_wr_addr = slot_w[RIDX_W-1:0];
    assign ptr_wr_data = ptr_clamped[PTR_W-1:0];

    assign ent_wr_en   = accept && (command == CMD_LOAD_ENTRY) && (slot_w < MAX_ENTRIES_W);
    assign ent_wr_addr = slot_w[EIDX_W-1:0];
    assign ent_wr_data = {entry_column_masked(entry_column), entry_value};

    // Row pointer memory.
    csle_ram #(
        .DEPTH  (MAX_ROWS + 1),
        .ADDR_W (RIDX_W),
        .DATA_W (PTR_W)
    ) u_ptr_ram (
        .clk     (clk),
        .wr_en   (ptr_wr_en),
        .wr_addr (ptr_wr_addr),
        .wr_data (ptr_wr_data),
        .rd_en   (ptr_rd_en),
        .rd_addr (ptr_rd_addr),
        .rd_data (ptr_rd_data)
    );

    // Entry memory: column index over value.
    csle_ram #(
        .DEPTH  (MAX_ENTRIES),
        .ADDR_W (EIDX_W),
        .DATA_W (ENT_W)
    ) u_ent_ram (
        .clk     (clk),
        .wr_en   (ent_wr_en),
        .wr_addr (ent_wr_addr),
        .wr_data (ent_wr_data),
        .rd_en   (ent_rd_en),
        .rd_addr (ent_rd_addr),
        .rd_data (ent_rd_data)
    );

    // Scan compare terms.
    assign scan_col  = 32'(ent_rd_data[ENT_W-1:VAL_W]);
    assign scan_qcol = 32'(qcol_reg);
    assign idx_inc   = 32'(idx_reg) + 32'd1;

    // State register and control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        qrow_reg          <= qrow_next;
        qcol_reg          <= qcol_next;
        first_reg         <= first_next;
        last_reg          <= last_next;
        idx_reg           <= idx_next;
        element_value_reg <= element_value_next;
        status_reg        <= status_next;
    end

    // Next state, memory reads and result.
    always_comb
    begin
        state_next         = state_reg;
        qrow_next          = qrow_reg;
        qcol_next          = qcol_reg;
        first_next         = first_reg;
        last_next          = last_reg;
        idx_next           = idx_reg;
        result_valid_next  = 1'b0;
        element_value_next = element_value_reg;
        status_next        = status_reg;
        ptr_rd_en          = 1'b0;
        ptr_rd_addr        = qrow_reg;
        ent_rd_en          = 1'b0;
        ent_rd_addr        = first_reg[EIDX_W-1:0];

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (command == CMD_LOOKUP))
                begin
                    priority if (check.bad_dim)
                    begin
                        result_valid_next  = 1'b1;
                        element_value_next = '0;
                        status_next        = STAT_BAD_DIM;
                    end
                    else if (check.out_of_bounds)
                    begin
                        result_valid_next  = 1'b1;
                        element_value_next = '0;
                        status_next        = STAT_OOB;
                    end
                    else
                    begin
                        // The row lies below the row count, so it fits the index.
                        ptr_rd_en   = 1'b1;
                        ptr_rd_addr = RIDX_W'(query_row);
                        qrow_next   = RIDX_W'(query_row);
                        qcol_next   = query_col;
                        state_next  = ST_PTR0;
                    end
                end
            end

            ST_PTR0:
            begin
                // Row start arrives; fetch the next row's start as the end.
                first_next  = ptr_rd_data;
                ptr_rd_en   = 1'b1;
                ptr_rd_addr = qrow_reg + RIDX_W'(1);
                state_next  = ST_PTR1;
            end

            ST_PTR1:
            begin
                last_next = ptr_rd_data;
                if ((first_reg < ptr_rd_data) && (32'(first_reg) < MAX_ENTRIES_W))
                begin
                    ent_rd_en   = 1'b1;
                    ent_rd_addr = first_reg[EIDX_W-1:0];
                    idx_next    = first_reg;
                    state_next  = ST_SCAN;
                end
                else
                begin
                    // Empty or inverted row.
                    result_valid_next  = 1'b1;
                    element_value_next = '0;
                    status_next        = STAT_OK;
                    state_next         = ST_IDLE;
                end
            end

            ST_SCAN:
            begin
                priority if (scan_col == scan_qcol)
                begin
                    result_valid_next  = 1'b1;
                    element_value_next = ent_rd_data[VAL_W-1:0];
                    status_next        = STAT_OK;
                    state_next         = ST_IDLE;
                end
                else if ((scan_col > scan_qcol) || (idx_inc >= 32'(last_reg)) ||
                         (idx_inc >= MAX_ENTRIES_W))
                begin
                    // Passed the target column or ran off the row.
                    result_valid_next  = 1'b1;
                    element_value_next = '0;
                    status_next        = STAT_OK;
                    state_next         = ST_IDLE;
                end
                else
                begin
                    ent_rd_en   = 1'b1;
                    ent_rd_addr = idx_inc[EIDX_W-1:0];
                    idx_next    = idx_inc[PTR_W-1:0];
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign result_valid  = result_valid_reg;
    assign element_value = element_value_reg;
    assign status        = status_reg;

endmodule : csle_seq
`default_nettype wire

// ===== tb/csr_sparse_element_lookup_core_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// csr_sparse_element_lookup_core_test
// Self-checking bench for the compressed-row element lookup. Beats load row
// pointers and entries or ask for one element. A shadow copy of the stores and
// the geometry registers predicts every lookup, and each strobed result is
// compared against the oldest pending prediction.
// ----------------------------------------------------------------------------
module csr_sparse_element_lookup_core_test;

    import csle_pkg::*;

    localparam int MAX_ROWS      = DEF_MAX_ROWS;
    localparam int MAX_ENTRIES   = DEF_MAX_ENTRIES;
    localparam int COL_SPAN      = 1 << QCOL_W;
    localparam int SETTLE_CYCLES = 8;
    localparam int TIMEOUT_NS    = 2_000_000;
    localparam int PRINT_CAP     = 100;

    // Command code with no function; the block drops it.
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    // One input beat, all fields as on the ports.
    typedef struct packed {
        logic [CMD_W-1:0]    command;
        logic [SLOT_W-1:0]   slot;
        logic [PTR_IN_W-1:0] row_pointer;
        logic [ECOL_W-1:0]   entry_column;
        logic [VAL_W-1:0]    entry_value;
        logic [QROW_W-1:0]   query_row;
        logic [QCOL_W-1:0]   query_col;
    } beat_t;

    // Predicted lookup answer, with the query kept for messages.
    typedef struct packed {
        logic [VAL_W-1:0]  value;
        logic [STAT_W-1:0] status;
        logic              hit;
        logic [QROW_W-1:0] qrow;
        logic [QCOL_W-1:0] qcol;
    } element_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  start;
    logic                  busy;
    logic [CMD_W-1:0]      command;
    logic [SLOT_W-1:0]     slot;
    logic [PTR_IN_W-1:0]   row_pointer;
    logic [ECOL_W-1:0]     entry_column;
    logic [VAL_W-1:0]      entry_value;
    logic [QROW_W-1:0]     query_row;
    logic [QCOL_W-1:0]     query_col;
    logic                  result_valid;
    logic [VAL_W-1:0]      element_value;
    logic [STAT_W-1:0]     status;

    // Shadow stores and geometry registers.
    logic [PTR_IN_W-1:0] ptr_shadow   [0:MAX_ROWS];
    bit                  ptr_loaded   [0:MAX_ROWS];
    logic [ECOL_W-1:0]   col_shadow   [0:MAX_ENTRIES-1];
    logic [VAL_W-1:0]    val_shadow   [0:MAX_ENTRIES-1];
    bit                  entry_loaded [0:MAX_ENTRIES-1];
    logic [ROWCNT_W-1:0] cfg_rows;
    logic [COLCNT_W-1:0] cfg_cols;

    element_t pending_elements [$];

    int idle_pct;
    int error_count;
    int useful_beats;
    int lookup_count;
    int hit_count;
    int absent_count;
    int dim_error_count;
    int bound_error_count;
    int register_writes;
    int results_seen;

    csr_sparse_element_lookup_core uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .start         (start),
        .busy          (busy),
        .command       (command),
        .slot          (slot),
        .row_pointer   (row_pointer),
        .entry_column  (entry_column),
        .entry_value   (entry_value),
        .query_row     (query_row),
        .query_col     (query_col),
        .result_valid  (result_valid),
        .element_value (element_value),
        .status        (status)
    );

    always #2 clk = ~clk;

    // Prints one line per mismatch, up to a cap, and counts them all.
    task automatic flag_mismatch(input string msg);
        if (error_count < PRINT_CAP)
        begin
            $display("MISMATCH at %0t ns: %s", $time, msg);
        end
        error_count++;
    endtask

    // Answer of a lookup against the shadow state. Also tells whether the
    // scan would touch a row pointer or an entry that was never loaded.
    function automatic element_t predict_lookup(input logic [QROW_W-1:0] qr,
                                                input logic [QCOL_W-1:0] qc,
                                                output bit touches_unloaded);
        element_t answer;
        int       rows_lim;
        int       first;
        int       last;
        answer = '0;
        answer.status = STAT_OK;
        answer.qrow = qr;
        answer.qcol = qc;
        touches_unloaded = 1'b0;
        rows_lim = (int'(cfg_rows) > MAX_ROWS) ? MAX_ROWS : int'(cfg_rows);
        if (cfg_rows == 0 || cfg_cols == 0)
        begin
            answer.status = STAT_BAD_DIM;
        end
        else if (int'(qr) >= rows_lim || int'(qc) >= int'(cfg_cols))
        begin
            answer.status = STAT_OOB;
        end
        else if (!ptr_loaded[qr] || !ptr_loaded[int'(qr) + 1])
        begin
            touches_unloaded = 1'b1;
        end
        else
        begin
            first = int'(ptr_shadow[qr]);
            last  = int'(ptr_shadow[int'(qr) + 1]);
            // Walk the row in stored order; stop on a match or a larger column.
            for (int i = first; i < last && i < MAX_ENTRIES; i++)
            begin
                if (!entry_loaded[i])
                begin
                    touches_unloaded = 1'b1;
                    break;
                end
                if (col_shadow[i] == qc)
                begin
                    answer.value = val_shadow[i];
                    answer.hit = 1'b1;
                    break;
                end
                if (col_shadow[i] > qc)
                begin
                    break;
                end
            end
        end
        return answer;
    endfunction

    // Updates the shadow state for an accepted beat and queues any answer.
    function automatic void apply_beat(input beat_t b);
        element_t answer;
        bit       unloaded;
        case (b.command)
            CMD_LOAD_PTR:
            begin
                if (int'(b.slot) <= MAX_ROWS)
                begin
                    ptr_shadow[b.slot] = (int'(b.row_pointer) > MAX_ENTRIES) ?
                                         PTR_IN_W'(MAX_ENTRIES) : b.row_pointer;
                    ptr_loaded[b.slot] = 1'b1;
                    useful_beats++;
                end
            end
            CMD_LOAD_ENTRY:
            begin
                col_shadow[b.slot]   = b.entry_column;
                val_shadow[b.slot]   = b.entry_value;
                entry_loaded[b.slot] = 1'b1;
                useful_beats++;
            end
            CMD_LOOKUP:
            begin
                answer = predict_lookup(b.query_row, b.query_col, unloaded);
                pending_elements.push_back(answer);
                useful_beats++;
                lookup_count++;
                if (answer.status == STAT_BAD_DIM)
                    dim_error_count++;
                else if (answer.status == STAT_OOB)
                    bound_error_count++;
                else if (answer.hit)
                    hit_count++;
                else
                    absent_count++;
            end
            default:
            begin
            end
        endcase
    endfunction

    function automatic beat_t random_beat();
        beat_t b;
        b.command      = CMD_W'($urandom_range(0, 3));
        b.slot         = SLOT_W'($urandom());
        b.row_pointer  = PTR_IN_W'($urandom());
        b.entry_column = ECOL_W'($urandom());
        b.entry_value  = {$urandom(), $urandom()};
        b.query_row    = QROW_W'($urandom());
        b.query_col    = QCOL_W'($urandom());
        return b;
    endfunction

    function automatic beat_t pointer_beat(input int s, input int p);
        beat_t b;
        b = random_beat();
        b.command     = CMD_LOAD_PTR;
        b.slot        = SLOT_W'(s);
        b.row_pointer = PTR_IN_W'(p);
        return b;
    endfunction

    function automatic beat_t entry_beat(input int s, input int c, input logic [VAL_W-1:0] v);
        beat_t b;
        b = random_beat();
        b.command      = CMD_LOAD_ENTRY;
        b.slot         = SLOT_W'(s);
        b.entry_column = ECOL_W'(c);
        b.entry_value  = v;
        return b;
    endfunction

    // Sends one beat after a random idle gap. Start is left high on return;
    // the next beat or the settle task decides what it does next.
    task automatic send_beat(input beat_t b);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start        <= 1'b1;
        command      <= b.command;
        slot         <= b.slot;
        row_pointer  <= b.row_pointer;
        entry_column <= b.entry_column;
        entry_value  <= b.entry_value;
        query_row    <= b.query_row;
        query_col    <= b.query_col;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        apply_beat(b);
    endtask

    // Sends a lookup only if its scan stays inside loaded store entries.
    task automatic lookup_element(input int qr, input int qc, output bit sent);
        beat_t    b;
        element_t probe;
        bit       unloaded;
        probe = predict_lookup(QROW_W'(qr), QCOL_W'(qc), unloaded);
        sent = !unloaded;
        if (sent)
        begin
            b = random_beat();
            b.command   = CMD_LOOKUP;
            b.query_row = QROW_W'(qr);
            b.query_col = QCOL_W'(qc);
            send_beat(b);
        end
    endtask

    // Holds off the sender until every predicted answer has arrived and
    // the block has had time to finish any load.
    task automatic settle_block();
        start <= 1'b0;
        @(posedge clk);
        while (pending_elements.size() != 0 || busy)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        settle_block();
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        if (idx == CFG_ROW_COUNT)
            cfg_rows = data[ROWCNT_W-1:0];
        else
            cfg_cols = data[COLCNT_W-1:0];
        register_writes++;
        cfg_wr_en <= 1'b0;
    endtask

    // Row count goes out with random upper bits, which the block must drop.
    task automatic configure(input int rows, input int cols);
        logic [CFG_DATA_W-1:0] data;
        data = CFG_DATA_W'($urandom());
        data[ROWCNT_W-1:0] = ROWCNT_W'(rows);
        write_register(CFG_ROW_COUNT, data);
        write_register(CFG_COL_COUNT, CFG_DATA_W'(cols));
    endtask

    // Geometry errors from reset and from each register alone, then bounds.
    task automatic test_geometry_checks();
        bit sent;
        idle_pct = 0;
        lookup_element(0, 0, sent);
        write_register(CFG_ROW_COUNT, CFG_DATA_W'(3));
        lookup_element(1, 1, sent);
        write_register(CFG_ROW_COUNT, CFG_DATA_W'(0));
        write_register(CFG_COL_COUNT, CFG_DATA_W'(16));
        lookup_element(0, 0, sent);
        write_register(CFG_ROW_COUNT, CFG_DATA_W'(3));
        lookup_element(3, 0, sent);
        lookup_element(1023, 0, sent);
        lookup_element(0, 16, sent);
        lookup_element(2, 65535, sent);
        settle_block();
    endtask

    // A small hand-built matrix with edge values, empty and inverted rows,
    // dropped beats, then the top row and entry with a clamped pointer.
    task automatic test_directed_matrix();
        bit sent;
        idle_pct = 0;
        configure(3, COL_SPAN);
        send_beat(pointer_beat(0, 0));
        send_beat(pointer_beat(1, 3));
        send_beat(pointer_beat(2, 3));
        send_beat(pointer_beat(3, 1));
        send_beat(entry_beat(0, 0, '1));
        send_beat(entry_beat(1, 700, 64'h0123_4567_89AB_CDEF));
        send_beat(entry_beat(2, 65535, '0));
        // Neither of these may change any store.
        send_beat(pointer_beat(2049, 5));
        begin
            beat_t noise;
            noise = random_beat();
            noise.command = CMD_UNUSED;
            send_beat(noise);
        end
        lookup_element(0, 0, sent);
        lookup_element(0, 700, sent);
        lookup_element(0, 65535, sent);
        lookup_element(0, 699, sent);
        lookup_element(1, 5, sent);
        lookup_element(2, 5, sent);
        // Row count above capacity lets the last row through.
        configure(2047, 131071);
        send_beat(pointer_beat(1023, 4095));
        send_beat(pointer_beat(1024, 8191));
        send_beat(entry_beat(4095, 9, {$urandom(), $urandom()}));
        lookup_element(1023, 9, sent);
        lookup_element(1023, 65535, sent);
        settle_block();
    endtask

    // One geometry, a few consecutive rows loaded in shuffled order with
    // some noise, then lookups of which about half aim at stored elements.
    task automatic run_random_set();
        int    rows;
        int    cols;
        int    rows_lim;
        int    col_lim;
        int    nrows;
        int    base;
        int    total;
        int    ebase;
        int    len;
        int    n;
        int    pos;
        int    v;
        int    p;
        int    e;
        int    k;
        int    kind;
        int    qr_i;
        int    qc_i;
        int    nlook;
        int    row_len   [0:5];
        int    row_first [0:5];
        int    row_tmp   [0:39];
        int    flat_cols [0:255];
        beat_t loads [$];
        beat_t b;
        beat_t tmp;
        bit    sent;
        logic [VAL_W-1:0] value;

        case ($urandom_range(0, 11))
            0:       rows = 0;
            1:       rows = 1;
            2:       rows = MAX_ROWS;
            3:       rows = $urandom_range(MAX_ROWS + 1, 2047);
            default: rows = $urandom_range(2, 64);
        endcase
        case ($urandom_range(0, 11))
            0:       cols = 0;
            1:       cols = 1;
            2:       cols = COL_SPAN - 1;
            3:       cols = COL_SPAN;
            4:       cols = $urandom_range(COL_SPAN + 1, 131071);
            5, 6:    cols = $urandom_range(2, 64);
            default: cols = $urandom_range(2, COL_SPAN - 1);
        endcase
        configure(rows, cols);
        rows_lim = (rows == 0 || rows > MAX_ROWS) ? MAX_ROWS : rows;
        col_lim  = (cols == 0 || cols > COL_SPAN) ? COL_SPAN : cols;
        nrows = $urandom_range(1, (rows_lim < 6) ? rows_lim : 6);
        base  = $urandom_range(0, rows_lim - nrows);

        // Columns of each row, sorted and distinct; a few rows get scrambled.
        total = 0;
        for (int r = 0; r < nrows; r++)
        begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(16, 40) : $urandom_range(0, 5);
            n = 0;
            repeat (len)
            begin
                v = $urandom_range(0, col_lim - 1);
                pos = 0;
                while (pos < n && row_tmp[pos] < v)
                    pos++;
                if (!(pos < n && row_tmp[pos] == v))
                begin
                    for (int i = n; i > pos; i--)
                        row_tmp[i] = row_tmp[i - 1];
                    row_tmp[pos] = v;
                    n++;
                end
            end
            if (n >= 2 && $urandom_range(0, 9) == 0)
            begin
                pos = $urandom_range(0, n - 1);
                v = row_tmp[0];
                row_tmp[0] = row_tmp[pos];
                row_tmp[pos] = v;
            end
            row_len[r] = n;
            for (int i = 0; i < n; i++)
                flat_cols[total + i] = row_tmp[i];
            total += n;
        end
        ebase = ($urandom_range(0, 7) == 0) ? MAX_ENTRIES - total :
                $urandom_range(0, MAX_ENTRIES - total);

        // Row pointers, with an occasional missing, inverted or clamped one.
        p = ebase;
        for (k = 0; k <= nrows; k++)
        begin
            if (k < nrows)
                row_first[k] = p;
            v = p;
            if (k == nrows && v == MAX_ENTRIES && $urandom_range(0, 1) == 1)
                v = $urandom_range(MAX_ENTRIES, 8191);
            if (k > 0 && k < nrows && $urandom_range(0, 9) == 0)
                v = $urandom_range(0, MAX_ENTRIES - 1);
            if ($urandom_range(0, 11) != 0)
                loads.push_back(pointer_beat(base + k, v));
            if (k < nrows)
                p += row_len[k];
        end
        for (int i = 0; i < total; i++)
        begin
            case ($urandom_range(0, 15))
                0:       value = '0;
                1:       value = '1;
                default: value = {$urandom(), $urandom()};
            endcase
            loads.push_back(entry_beat(ebase + i, flat_cols[i], value));
        end
        // Beats the block must drop.
        repeat ($urandom_range(0, 2))
        begin
            b = random_beat();
            if ($urandom_range(0, 1) == 1)
                b.command = CMD_UNUSED;
            else
                b = pointer_beat($urandom_range(MAX_ROWS + 1, 4095), $urandom_range(0, 8191));
            loads.push_back(b);
        end
        for (int i = loads.size() - 1; i > 0; i--)
        begin
            pos = $urandom_range(0, i);
            tmp = loads[i];
            loads[i] = loads[pos];
            loads[pos] = tmp;
        end
        foreach (loads[i])
            send_beat(loads[i]);

        nlook = $urandom_range(8, 20);
        repeat (nlook)
        begin
            // Now and then a stored value changes between lookups.
            if (total > 0 && $urandom_range(0, 7) == 0)
            begin
                e = ebase + $urandom_range(0, total - 1);
                send_beat(entry_beat(e, int'(col_shadow[e]), {$urandom(), $urandom()}));
            end
            kind = $urandom_range(0, 9);
            k = $urandom_range(0, nrows - 1);
            qr_i = base + k;
            qc_i = $urandom_range(0, col_lim - 1);
            if (kind < 5 && row_len[k] > 0)
            begin
                qc_i = int'(col_shadow[row_first[k] + $urandom_range(0, row_len[k] - 1)]);
            end
            else if (kind == 5 && row_len[k] > 0)
            begin
                v = int'(col_shadow[row_first[k] + $urandom_range(0, row_len[k] - 1)]);
                qc_i = ($urandom_range(0, 1) == 1) ? v + 1 : v - 1;
                if (qc_i < 0 || qc_i >= COL_SPAN)
                    qc_i = v;
            end
            else if (kind == 7)
            begin
                qr_i = $urandom_range(0, MAX_ROWS - 1);
                qc_i = $urandom_range(0, COL_SPAN - 1);
            end
            else if (kind == 8)
            begin
                qc_i = $urandom_range(0, COL_SPAN - 1);
            end
            else if (kind == 9)
            begin
                qr_i = $urandom_range(0, MAX_ROWS - 1);
            end
            lookup_element(qr_i, qc_i, sent);
        end
        settle_block();
    endtask

    task automatic test_random_sets(input int pct, input int quota);
        int target;
        idle_pct = pct;
        target = useful_beats + quota;
        while (useful_beats < target)
            run_random_set();
    endtask

    // Every strobed result is matched against the oldest prediction.
    always @(posedge clk)
    begin : result_check
        element_t want;
        if (rst_n === 1'b1 && result_valid !== 1'b0)
        begin
            if (pending_elements.size() == 0)
            begin
                flag_mismatch($sformatf("result with no lookup pending: value %h status %0d",
                                        element_value, status));
            end
            else
            begin
                want = pending_elements.pop_front();
                results_seen++;
                if (element_value !== want.value)
                    flag_mismatch($sformatf("row %0d col %0d: value %h, expected %h",
                                            want.qrow, want.qcol, element_value, want.value));
                if (status !== want.status)
                    flag_mismatch($sformatf("row %0d col %0d: status %0d, expected %0d",
                                            want.qrow, want.qcol, status, want.status));
            end
        end
    end

    initial
    begin
        rst_n        = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_index    = '0;
        cfg_wdata    = '0;
        start        = 1'b0;
        command      = '0;
        slot         = '0;
        row_pointer  = '0;
        entry_column = '0;
        entry_value  = '0;
        query_row    = '0;
        query_col    = '0;
        cfg_rows     = '0;
        cfg_cols     = '0;
        for (int i = 0; i <= MAX_ROWS; i++)
        begin
            ptr_shadow[i] = '0;
            ptr_loaded[i] = 1'b0;
        end
        for (int i = 0; i < MAX_ENTRIES; i++)
            entry_loaded[i] = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        test_geometry_checks();
        test_directed_matrix();
        test_random_sets(0, 150);
        test_random_sets(88, 150);
        test_random_sets(12, 150);
        settle_block();

        $display("Covered %0d beats and %0d register writes; %0d lookups gave %0d hits,",
                 useful_beats, register_writes, lookup_count, hit_count);
        $display("%0d absent, %0d geometry and %0d bound errors; %0d results compared.",
                 absent_count, dim_error_count, bound_error_count, results_seen);
        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("Timeout: the run did not complete");
        $display("Some tests failed");
        $finish;
    end

endmodule
